// ----- hdl/xoshiro256ss_bounded_random_top_defines.svh -----
// Assertion macros shared by the block's top level
`ifndef XOSHIRO256SS_BOUNDED_RANDOM_TOP_DEFINES_SVH
`define XOSHIRO256SS_BOUNDED_RANDOM_TOP_DEFINES_SVH

// condition implies consequence on the same edge (clock and reset of the user)
`define XRB_ASSERT_IMPLY(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// condition implies consequence on the next edge (clock and reset of the user)
`define XRB_ASSERT_NEXT(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/xrb_pkg.sv -----
package xrb_pkg;

   localparam int unsigned WordWidth = 64;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [1:0]           func_type;

   localparam func_type FuncSeed  = 2'd0;
   localparam func_type FuncRaw   = 2'd1;
   localparam func_type FuncRange = 2'd2;

   localparam word_type GoldenGamma = 64'h9E3779B97F4A7C15;
   localparam word_type MixMulA     = 64'hBF58476D1CE4E5B9;
   localparam word_type MixMulB     = 64'h94D049BB133111EB;
   localparam int unsigned WordRot   = 45;
   localparam int unsigned WordShift = 17;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE     = 4'd0,
      OP_LOAD     = 4'd1,  // capture request fields
      OP_SEED_ADD = 4'd2,  // acc += gamma
      OP_MIX_A    = 4'd3,  // z = (acc ^ acc>>30), multiply start (A)
      OP_MIX_B    = 4'd4,  // z = (z ^ z>>27), multiply start (B)
      OP_SEED_WR  = 4'd5,  // write z ^ z>>31 into word[idx]
      OP_DRAW     = 4'd6,  // advance generator, capture output
      OP_DIV_INIT = 4'd7,  // start divider
      OP_DIV_STEP = 4'd8,  // one remainder bit
      OP_RES_LOW  = 4'd9,  // result = low
      OP_RES_RAW  = 4'd10, // result = draw
      OP_RES_MOD  = 4'd11, // result = low + remainder
      OP_MUL_STEP = 4'd12  // one partial product step
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] idx;
      logic       div_limit;  // divider computes limit (1) or draw mod range (0)
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     range_empty;
      logic     range_full;
      logic     words_zero;
      logic     below_limit;
      logic     div_done;
      logic     mul_done;
   } status_type;

endpackage

// ----- hdl/xrb_datapath.sv -----
module xrb_datapath (
   input  logic                clock,
   input  logic                reset,
   input  xrb_pkg::cmd_type    cmd,
   output xrb_pkg::status_type status,
   input  xrb_pkg::func_type   req_func,
   input  xrb_pkg::word_type   req_seed_value,
   input  xrb_pkg::word_type   req_range_low,
   input  xrb_pkg::word_type   req_range_high,
   output xrb_pkg::word_type   result
);

   xrb_pkg::word_type w_ff [4];
   xrb_pkg::word_type w_in [4];
   xrb_pkg::func_type func_ff;
   xrb_pkg::word_type low_ff, high_ff, range_ff, limit_ff;
   xrb_pkg::word_type acc_ff, acc_in, draw_ff, draw_in;
   xrb_pkg::word_type rem_ff, rem_in, num_ff, num_in, res_ff, res_in;
   xrb_pkg::word_type mul_ff, mul_in, mop_ff, mop_in, mk_ff, mk_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [64:0] rem_sh;
   xrb_pkg::word_type span, rot_in;

   assign span = high_ff - low_ff;
   assign rot_in = (w_ff[1] * 64'd5);

   always_comb begin
      xrb_pkg::word_type t, sh, r2, w0, w1, w2, w3;
      for (int i = 0; i < 4; i++) w_in[i] = w_ff[i];
      acc_in  = acc_ff;
      draw_in = draw_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      res_in  = res_ff;
      cnt_in  = cnt_ff;
      mul_in  = mul_ff;
      mop_in  = mop_ff;
      mk_in   = mk_ff;
      rem_sh  = '0;
      t  = '0; sh = '0; r2 = '0;
      w0 = w_ff[0]; w1 = w_ff[1]; w2 = w_ff[2]; w3 = w_ff[3];
      case (cmd.op)
         xrb_pkg::OP_LOAD: begin
            acc_in = req_seed_value;
         end
         xrb_pkg::OP_SEED_ADD: begin
            acc_in = acc_ff + xrb_pkg::GoldenGamma;
         end
         // multiply operand by constant, 8 bits per step
         xrb_pkg::OP_MIX_A: begin
            mop_in = acc_ff ^ (acc_ff >> 30);
            mk_in  = xrb_pkg::MixMulA;
            mul_in = '0;
            cnt_in = '0;
         end
         xrb_pkg::OP_MIX_B: begin
            mop_in = mul_ff ^ (mul_ff >> 27);
            mk_in  = xrb_pkg::MixMulB;
            mul_in = '0;
            cnt_in = '0;
         end
         xrb_pkg::OP_MUL_STEP: begin
            mul_in = mul_ff + ((mop_ff * {56'd0, mk_ff[7:0]}) << {cnt_ff[2:0], 3'd0});
            mk_in  = mk_ff >> 8;
            cnt_in = cnt_ff + 7'd1;
         end
         xrb_pkg::OP_SEED_WR: begin
            w_in[cmd.idx] = mul_ff ^ (mul_ff >> 31);
         end
         // one xoshiro256** step
         xrb_pkg::OP_DRAW: begin
            r2 = {rot_in[56:0], rot_in[63:57]};
            draw_in = (r2 << 3) + r2;
            sh = w1 << xrb_pkg::WordShift;
            w2 = w2 ^ w0;
            w3 = w3 ^ w1;
            w1 = w1 ^ w2;
            w0 = w0 ^ w3;
            w2 = w2 ^ sh;
            w3 = (w3 << xrb_pkg::WordRot) | (w3 >> (xrb_pkg::WordWidth - xrb_pkg::WordRot));
            w_in[0] = w0; w_in[1] = w1; w_in[2] = w2; w_in[3] = w3;
         end
         // limit start uses the live span: range_ff is not yet loaded
         xrb_pkg::OP_DIV_INIT: begin
            num_in = cmd.div_limit ? (64'd0 - (span + 64'd1)) : draw_ff;
            rem_in = '0;
            cnt_in = '0;
         end
         // restoring division, one bit per step
         xrb_pkg::OP_DIV_STEP: begin
            rem_sh = {rem_ff, num_ff[63]};
            num_in = num_ff << 1;
            if (rem_sh >= {1'b0, range_ff}) begin
               t = 64'(rem_sh - {1'b0, range_ff});
            end else begin
               t = rem_sh[63:0];
            end
            rem_in = t;
            cnt_in = cnt_ff + 7'd1;
         end
         xrb_pkg::OP_RES_LOW: res_in = low_ff;
         xrb_pkg::OP_RES_RAW: res_in = draw_ff;
         xrb_pkg::OP_RES_MOD: res_in = low_ff + rem_ff;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) w_ff[i] <= '0;
      end else begin
         for (int i = 0; i < 4; i++) w_ff[i] <= w_in[i];
      end
      acc_ff  <= acc_in;
      draw_ff <= draw_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      res_ff  <= res_in;
      cnt_ff  <= cnt_in;
      mul_ff  <= mul_in;
      mop_ff  <= mop_in;
      mk_ff   <= mk_in;
      if (cmd.op == xrb_pkg::OP_LOAD) begin
         func_ff <= req_func;
         low_ff  <= req_range_low;
         high_ff <= req_range_high;
      end
      range_ff <= span + 64'd1;
      if (cmd.op == xrb_pkg::OP_DIV_STEP && cmd.div_limit && cnt_ff == 7'd63) begin
         limit_ff <= rem_in;
      end
   end

   assign status.func        = func_ff;
   assign status.range_empty = (low_ff >= high_ff);
   assign status.range_full  = (span == '1);
   assign status.words_zero  = ((w_ff[0] | w_ff[1] | w_ff[2] | w_ff[3]) == '0);
   assign status.below_limit = (draw_ff < limit_ff);
   assign status.div_done    = (cnt_ff == 7'd64);
   assign status.mul_done    = (cnt_ff == 7'd8);
   assign result = res_ff;

endmodule

// ----- hdl/xrb_control.sv -----
module xrb_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  xrb_pkg::status_type status,
   output xrb_pkg::cmd_type    cmd
);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_DEC    = 11'b00000000010,
      S_SADD   = 11'b00000000100,
      S_MULA   = 11'b00000001000,
      S_MULB   = 11'b00000010000,
      S_SWR    = 11'b00000100000,
      S_LIM    = 11'b00001000000,
      S_DRAW   = 11'b00010000000,
      S_CHECK  = 11'b00100000000,
      S_MOD    = 11'b01000000000,
      S_RESP   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic       phase_ff, phase_in;  // multiply phase: 0 in step, 1 running
   logic       raw_ff, raw_in;      // draw result is returned directly
   logic       out_ff, out_in;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      phase_in = phase_ff;
      raw_in   = raw_ff;
      out_in   = out_ff;
      cmd      = '{op: xrb_pkg::OP_NONE, idx: idx_ff, div_limit: 1'b0};
      if (out_ff && !rsp_stall) out_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !out_ff) begin
               cmd.op   = xrb_pkg::OP_LOAD;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            case (status.func)
               xrb_pkg::FuncSeed: begin
                  idx_in = 2'd0;
                  state_in = S_SADD;
               end
               xrb_pkg::FuncRaw: begin
                  raw_in = 1'b1;
                  state_in = S_DRAW;
               end
               xrb_pkg::FuncRange: begin
                  if (status.range_empty) begin
                     cmd.op = xrb_pkg::OP_RES_LOW;
                     state_in = S_RESP;
                  end else if (status.range_full) begin
                     raw_in = 1'b1;
                     state_in = S_DRAW;
                  end else begin
                     raw_in = 1'b0;
                     cmd.op = xrb_pkg::OP_DIV_INIT;
                     cmd.div_limit = 1'b1;
                     state_in = S_LIM;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         // splitmix64 over four words
         S_SADD: begin
            cmd.op = xrb_pkg::OP_SEED_ADD;
            phase_in = 1'b0;
            state_in = S_MULA;
         end
         S_MULA: begin
            if (!phase_ff) begin
               cmd.op = xrb_pkg::OP_MIX_A;
               phase_in = 1'b1;
            end else if (!status.mul_done) begin
               cmd.op = xrb_pkg::OP_MUL_STEP;
            end else begin
               cmd.op = xrb_pkg::OP_MIX_B;
               state_in = S_MULB;
            end
         end
         S_MULB: begin
            if (!status.mul_done) begin
               cmd.op = xrb_pkg::OP_MUL_STEP;
            end else begin
               state_in = S_SWR;
            end
         end
         S_SWR: begin
            cmd.op = xrb_pkg::OP_SEED_WR;
            idx_in = idx_ff + 2'd1;
            state_in = (idx_ff == 2'd3) ? S_IDLE : S_SADD;
         end
         // limit = 2^64 mod range
         S_LIM: begin
            cmd.div_limit = 1'b1;
            if (!status.div_done) begin
               cmd.op = xrb_pkg::OP_DIV_STEP;
            end else begin
               state_in = S_DRAW;
            end
         end
         S_DRAW: begin
            cmd.op = xrb_pkg::OP_DRAW;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (raw_ff) begin
               cmd.op = xrb_pkg::OP_RES_RAW;
               state_in = S_RESP;
            end else if (status.below_limit && !status.words_zero) begin
               state_in = S_DRAW;
            end else begin
               cmd.op = xrb_pkg::OP_DIV_INIT;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (!status.div_done) begin
               cmd.op = xrb_pkg::OP_DIV_STEP;
            end else begin
               cmd.op = xrb_pkg::OP_RES_MOD;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            out_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_ff   <= 1'b0;
         idx_ff   <= '0;
         phase_ff <= 1'b0;
         raw_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff   <= out_in;
         idx_ff   <= idx_in;
         phase_ff <= phase_in;
         raw_ff   <= raw_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE) || out_ff;
   assign rsp_valid = out_ff;

endmodule

// ----- hdl/xoshiro256ss_bounded_random_top.sv -----
// xoshiro256** generator with splitmix64 seeding and unbiased range draws.
// Request channel: req_valid/req_stall carry req_func, req_seed_value,
// req_range_low and req_range_high; a request is taken when req_valid is
// high and req_stall is low.
// Response channel: rsp_valid/rsp_stall carry rsp_value.
// Seed requests (func 0) and func 3 give no response.
// From the edge that takes a request to the first rsp_valid cycle, a raw
// draw and a full-span range pass the draw and check states; an empty or
// reversed range returns low with no draw; other range draws add two 64-step
// restoring divisions (limit and remainder) and a redraw on each rejection.
// A seed request runs eight 64x8-bit multiply passes of 8 steps each.
// One request is worked at a time; the next can be taken in the cycle after
// the response is taken, or once the block is idle after func 3 or seeding.
// Reset clears the generator words to zero and drops any pending response; the result register is not reset.
// A stalled response holds its value until taken.
`include "xoshiro256ss_bounded_random_top_defines.svh"

module xoshiro256ss_bounded_random_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  xrb_pkg::func_type req_func,
   input  xrb_pkg::word_type req_seed_value,
   input  xrb_pkg::word_type req_range_low,
   input  xrb_pkg::word_type req_range_high,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output xrb_pkg::word_type rsp_value
);

   xrb_pkg::cmd_type    cmd;
   xrb_pkg::status_type status;
   logic                rsp_held;

   xrb_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   xrb_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_func       (req_func),
      .req_seed_value (req_seed_value),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .result         (rsp_value)
   );

   // response offered but not taken this edge
   assign rsp_held = rsp_valid && rsp_stall;

   `XRB_ASSERT_IMPLY(a_no_accept_busy, rsp_valid, req_stall, "request accepted while busy")
   `XRB_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_value), "held response changed")

endmodule

// ----- test/xoshiro256ss_bounded_random_checker.sv -----
`timescale 1ns / 1ps

module xoshiro256ss_bounded_random_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  xrb_pkg::func_type req_func,
   input  xrb_pkg::word_type req_seed_value,
   input  xrb_pkg::word_type req_range_low,
   input  xrb_pkg::word_type req_range_high,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  xrb_pkg::word_type rsp_value,
   output int                error_count,
   output int                pending_count
);

   xrb_pkg::word_type gen_words [4];
   xrb_pkg::word_type expected_values [$];

   function automatic xrb_pkg::word_type rotl(xrb_pkg::word_type v, int unsigned amount);
      return (v << amount) | (v >> (64 - amount));
   endfunction

   function automatic xrb_pkg::word_type splitmix_next(ref xrb_pkg::word_type acc);
      xrb_pkg::word_type z;
      acc = acc + xrb_pkg::GoldenGamma;
      z = acc;
      z = (z ^ (z >> 30)) * xrb_pkg::MixMulA;
      z = (z ^ (z >> 27)) * xrb_pkg::MixMulB;
      return z ^ (z >> 31);
   endfunction

   function automatic xrb_pkg::word_type advance_generator();
      xrb_pkg::word_type res, sh;
      res = rotl(gen_words[1] * 64'd5, 7) * 64'd9;
      sh = gen_words[1] << xrb_pkg::WordShift;
      gen_words[2] ^= gen_words[0];
      gen_words[3] ^= gen_words[1];
      gen_words[1] ^= gen_words[2];
      gen_words[0] ^= gen_words[3];
      gen_words[2] ^= sh;
      gen_words[3] = rotl(gen_words[3], xrb_pkg::WordRot);
      return res;
   endfunction

   // apply one request to the generator copy, queue its value if any
   task automatic predict_request(xrb_pkg::func_type f, xrb_pkg::word_type seed,
                                  xrb_pkg::word_type lo, xrb_pkg::word_type hi);
      xrb_pkg::word_type acc, span, range, limit, x;
      bit all_zero;
      if (f == xrb_pkg::FuncSeed) begin
         acc = seed;
         for (int i = 0; i < 4; i++) gen_words[i] = splitmix_next(acc);
      end else if (f == xrb_pkg::FuncRaw) begin
         expected_values.push_back(advance_generator());
      end else if (f == xrb_pkg::FuncRange) begin
         if (lo >= hi) begin
            expected_values.push_back(lo);
         end else begin
            span = hi - lo;
            if (span == '1) begin
               expected_values.push_back(advance_generator());
            end else begin
               range = span + 64'd1;
               limit = (64'd0 - range) % range;
               all_zero = (gen_words[0] | gen_words[1] | gen_words[2] | gen_words[3]) == '0;
               x = advance_generator();
               if (!all_zero)
                  while (x < limit) x = advance_generator();
               expected_values.push_back(lo + x % range);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      xrb_pkg::word_type want;
      if (reset) begin
         for (int i = 0; i < 4; i++) gen_words[i] = '0;
         expected_values.delete();
         error_count <= 0;
         pending_count <= 0;
      end else begin
         // response side first; a request taken now cannot respond this edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_values.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected response value=%h", rsp_value);
               error_count <= error_count + 1;
            end else begin
               want = expected_values.pop_front();
               if (rsp_value !== want) begin
                  if (error_count < 10)
                     $display("value mismatch: expected %h actual %h", want, rsp_value);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            predict_request(req_func, req_seed_value, req_range_low, req_range_high);
         pending_count <= expected_values.size();
      end
   end
endmodule

// ----- test/tb_xoshiro256ss_bounded_random_top.sv -----
`timescale 1ns / 1ps

module tb_xoshiro256ss_bounded_random_top;

   localparam int IdleLimit = 20000;
   localparam xrb_pkg::func_type FuncUnused = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   xrb_pkg::func_type req_func = xrb_pkg::FuncSeed;
   xrb_pkg::word_type req_seed_value = '0;
   xrb_pkg::word_type req_range_low = '0;
   xrb_pkg::word_type req_range_high = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   xrb_pkg::word_type rsp_value;
   int                error_count, pending_count;
   int                send_idle_pct = 0, stall_pct = 0;
   bit                hold_rsp = 1'b0;
   int                idle_cycles = 0;

   always #10 clock = ~clock;

   xoshiro256ss_bounded_random_top DUT (.*);

   xoshiro256ss_bounded_random_checker checker_inst (.*);

   function automatic xrb_pkg::word_type rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // receiver stall, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // watchdog on acceptance activity
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // offer one request and wait for it to be taken
   task automatic send_request(xrb_pkg::func_type f, xrb_pkg::word_type seed,
                               xrb_pkg::word_type lo, xrb_pkg::word_type hi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_seed_value <= seed;
      req_range_low <= lo;
      req_range_high <= hi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // random request: mostly draws with small and wide ranges
   task automatic send_random();
      int pick;
      xrb_pkg::word_type lo, hi;
      pick = $urandom_range(99);
      lo = rand_word();
      if (pick < 8) send_request(xrb_pkg::FuncSeed, rand_word(), rand_word(), rand_word());
      else if (pick < 11) send_request(FuncUnused, rand_word(), rand_word(), rand_word());
      else if (pick < 40) send_request(xrb_pkg::FuncRaw, rand_word(), rand_word(), rand_word());
      else begin
         case ($urandom_range(4))
            0: hi = lo + 64'($urandom_range(20));
            1: hi = lo + {32'd0, $urandom()};
            2: hi = rand_word();
            3: begin
               lo = 64'($urandom_range(3));
               hi = '1 - 64'($urandom_range(3));
            end
            default: hi = lo + ({32'd1, 32'd0} << $urandom_range(31)) + 64'($urandom_range(7));
         endcase
         send_request(xrb_pkg::FuncRange, rand_word(), lo, hi);
      end
   endtask

   initial begin
      int phase_pct [4][2] = '{'{0, 0}, '{62, 0}, '{0, 62}, '{24, 24}};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unseeded generator draws
      send_request(xrb_pkg::FuncRaw, '0, '0, '0);
      send_request(xrb_pkg::FuncRange, '0, 64'd5, 64'd9);
      send_request(xrb_pkg::FuncRange, '0, 64'd0, '1);
      send_request(FuncUnused, '1, '1, '1);
      // seed extremes and raw draws
      send_request(xrb_pkg::FuncSeed, '0, '0, '0);
      send_request(xrb_pkg::FuncRaw, '1, '1, '1);
      send_request(xrb_pkg::FuncSeed, '1, '1, '1);
      send_request(xrb_pkg::FuncRaw, '0, '0, '0);
      // empty and reversed ranges
      send_request(xrb_pkg::FuncRange, '0, 64'd7, 64'd7);
      send_request(xrb_pkg::FuncRange, '0, '1, '0);
      send_request(xrb_pkg::FuncRange, '0, '1, '1);
      // full span and near-full spans
      send_request(xrb_pkg::FuncRange, '0, '0, '1);
      send_request(xrb_pkg::FuncRange, '0, 64'd1, '1);
      send_request(xrb_pkg::FuncRange, '0, '0, '1 - 64'd1);
      // ranges with large and small rejection limits
      send_request(xrb_pkg::FuncRange, '0, '0, 64'h8000_0000_0000_0000);
      send_request(xrb_pkg::FuncRange, '0, 64'd3, 64'hC000_0000_0000_0003);
      send_request(xrb_pkg::FuncRange, '0, '0, 64'd1);
      send_request(xrb_pkg::FuncRange, '0, 64'd100, 64'd102);
      send_request(FuncUnused, '0, '0, '0);
      send_request(xrb_pkg::FuncRaw, '0, '0, '0);
      drain_responses();

      // random phases with different idle mixes
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = phase_pct[p][0];
         stall_pct = phase_pct[p][1];
         repeat (100) send_random();
         if (p == 1) begin
            // sender pauses until all responses are in
            drain_responses();
         end
         if (p == 2) begin
            // long receiver hold-off while requests keep coming
            fork
               begin hold_rsp = 1'b1; repeat (400) @(posedge clock); hold_rsp = 1'b0; end
               repeat (6) send_random();
            join
         end
      end
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (20) send_random();
      drain_responses();

      for (int i = 0; i < 300 && pending_count == 0; i++) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
